@@ rtl/owm_pkg.sv @@
// Shared types, codes and constants of the 1-Wire bus master.
package owm_pkg;

  // Released-line time that closes every bit slot, in microseconds.
  parameter logic [9:0] RECOVERY_US = 10'd2;

  // Register reset values.
  parameter logic [9:0] RESET_LOW_US_RST      = 10'd500;
  parameter logic [7:0] PRESENCE_DELAY_US_RST = 8'd70;
  parameter logic [9:0] PRESENCE_TAIL_US_RST  = 10'd420;
  parameter logic [7:0] SLOT_US_RST           = 8'd70;
  parameter logic [7:0] WRITE_ONE_LOW_US_RST  = 8'd5;
  parameter logic [7:0] WRITE_ZERO_LOW_US_RST = 8'd70;
  parameter logic [7:0] READ_LOW_US_RST       = 8'd2;
  parameter logic [7:0] READ_SAMPLE_US_RST    = 8'd8;

  parameter logic STATUS_OK          = 1'b0;
  parameter logic STATUS_NO_PRESENCE = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_TAIL  = 4'd3,
    PH_BIT_LOW   = 4'd4,
    PH_BIT_WAIT  = 4'd5,
    PH_READ_TAIL = 4'd6,
    PH_RECOVER   = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW_US      = 3'd0,
    REG_PRESENCE_DELAY_US = 3'd1,
    REG_PRESENCE_TAIL_US  = 3'd2,
    REG_SLOT_US           = 3'd3,
    REG_WRITE_ONE_LOW_US  = 3'd4,
    REG_WRITE_ZERO_LOW_US = 3'd5,
    REG_READ_LOW_US       = 3'd6,
    REG_READ_SAMPLE_US    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       status;
  } result_t;

endpackage

@@ rtl/owm_item_if.sv @@
// Input channel: command, byte to send, line sample and microsecond tick.
interface owm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] tx_byte;
  logic       line_level;
  logic       tick;

  modport source (output valid, command, tx_byte, line_level, tick, input ready);
  modport sink (input valid, command, tx_byte, line_level, tick, output ready);
endinterface

@@ rtl/owm_result_if.sv @@
// Result channel: line drive and command status after each input transaction.
interface owm_result_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       status;

  modport source (output valid, drive_low, busy_res, done_res, rx_byte, status,
                  input ready);
  modport sink (input valid, drive_low, busy_res, done_res, rx_byte, status,
                output ready);
endinterface

@@ rtl/owm_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface owm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/onewire_bus_master.sv @@
// 1-Wire bus master: reset/presence, byte write and byte read sequencer.
//
//  channel  role    accepted when          carries
//  item     sink    valid & ready          command, tx_byte, line_level, tick
//  result   source  valid & ready          drive_low, busy_res, done_res, rx_byte, status
//  cfg      sink    valid (ready tied 1)   index, data
//
// Every input transaction makes one result transaction; one item per clock while item.ready is high.
// The sequencer state advances in the cycle an item is accepted, and the result
// is registered into the output register, or into the skid stage while the output is stalled.
// A second stage holds one result while the output is stalled; item.ready drops
// only when both stages are full.
// rst is synchronous: phase idle, counters cleared, registers at their defaults.
module onewire_bus_master (
  input  logic                 clk,
  input  logic                 rst,
  owm_item_if.sink             item,
  owm_result_if.source         result,
  owm_cfg_if.sink              cfg
);

  // Configuration registers
  logic [9:0] reset_low_us;
  logic [7:0] presence_delay_us;
  logic [9:0] presence_tail_us;
  logic [7:0] slot_us;
  logic [7:0] write_one_low_us;
  logic [7:0] write_zero_low_us;
  logic [7:0] read_low_us;
  logic [7:0] read_sample_us;

  // Sequencer state
  owm_pkg::phase_t phase, phase_next;
  owm_pkg::cmd_t   active_command, active_command_next;
  owm_pkg::cmd_t   item_cmd;
  logic [9:0] wait_count, wait_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] shift_wr;
  logic       last_status, last_status_next;
  logic [7:0] rx_last, rx_last_next;
  logic       done;
  logic       ended;

  logic [7:0] one_tail_us;
  logic [7:0] read_rest_us;
  logic [7:0] read_tail_us;

  owm_pkg::result_t res;
  owm_pkg::result_t out_data, skid_data;
  logic             out_valid, skid_valid;
  logic             acc, take;

  assign acc  = item.valid && item.ready;
  assign take = out_valid && result.ready;

  assign item.ready = !skid_valid;
  assign cfg.ready  = 1'b1;

  assign item_cmd = owm_pkg::cmd_t'(item.command);

  // Saturating slot remainders
  assign one_tail_us  = (slot_us > write_one_low_us) ? (slot_us - write_one_low_us) : 8'd0;
  assign read_rest_us = (slot_us > read_low_us) ? (slot_us - read_low_us) : 8'd0;
  assign read_tail_us = (read_rest_us > read_sample_us) ?
                        (read_rest_us - read_sample_us) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us      <= owm_pkg::RESET_LOW_US_RST;
      presence_delay_us <= owm_pkg::PRESENCE_DELAY_US_RST;
      presence_tail_us  <= owm_pkg::PRESENCE_TAIL_US_RST;
      slot_us           <= owm_pkg::SLOT_US_RST;
      write_one_low_us  <= owm_pkg::WRITE_ONE_LOW_US_RST;
      write_zero_low_us <= owm_pkg::WRITE_ZERO_LOW_US_RST;
      read_low_us       <= owm_pkg::READ_LOW_US_RST;
      read_sample_us    <= owm_pkg::READ_SAMPLE_US_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (owm_pkg::reg_idx_t'(cfg.index))
        owm_pkg::REG_RESET_LOW_US:      reset_low_us      <= cfg.data;
        owm_pkg::REG_PRESENCE_DELAY_US: presence_delay_us <= cfg.data[7:0];
        owm_pkg::REG_PRESENCE_TAIL_US:  presence_tail_us  <= cfg.data;
        owm_pkg::REG_SLOT_US:           slot_us           <= cfg.data[7:0];
        owm_pkg::REG_WRITE_ONE_LOW_US:  write_one_low_us  <= cfg.data[7:0];
        owm_pkg::REG_WRITE_ZERO_LOW_US: write_zero_low_us <= cfg.data[7:0];
        owm_pkg::REG_READ_LOW_US:       read_low_us       <= cfg.data[7:0];
        owm_pkg::REG_READ_SAMPLE_US:    read_sample_us    <= cfg.data[7:0];
        default:                        ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    wait_count_next     = wait_count;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    last_status_next    = last_status;
    rx_last_next        = rx_last;
    done                = 1'b0;
    ended               = 1'b0;
    shift_wr            = shift_byte;

    if (phase == owm_pkg::PH_IDLE) begin
      if (item_cmd == owm_pkg::CMD_RESET) begin
        active_command_next = owm_pkg::CMD_RESET;
        phase_next          = owm_pkg::PH_RST_LOW;
        wait_count_next     = reset_low_us;
      end else if (item_cmd == owm_pkg::CMD_WRITE || item_cmd == owm_pkg::CMD_READ) begin
        active_command_next = item_cmd;
        last_status_next    = owm_pkg::STATUS_OK;
        bit_index_next      = 3'd0;
        phase_next          = owm_pkg::PH_BIT_LOW;
        if (item_cmd == owm_pkg::CMD_WRITE) begin
          shift_byte_next = item.tx_byte;
          wait_count_next = {2'b00, item.tx_byte[0] ? write_one_low_us : write_zero_low_us};
        end else begin
          shift_byte_next = 8'd0;
          wait_count_next = {2'b00, read_low_us};
        end
      end
    end else begin
      // Phase ends when the count is already zero or reaches zero on this tick
      if (wait_count == 10'd0) begin
        ended = 1'b1;
      end else if (item.tick) begin
        wait_count_next = wait_count - 10'd1;
        ended           = (wait_count == 10'd1);
      end

      if (ended) begin
        unique case (phase)
          owm_pkg::PH_RST_LOW: begin
            phase_next      = owm_pkg::PH_RST_WAIT;
            wait_count_next = {2'b00, presence_delay_us};
          end
          owm_pkg::PH_RST_WAIT: begin
            if (!item.line_level) begin
              last_status_next = owm_pkg::STATUS_OK;
              phase_next       = owm_pkg::PH_RST_TAIL;
              wait_count_next  = presence_tail_us;
            end else begin
              last_status_next = owm_pkg::STATUS_NO_PRESENCE;
              phase_next       = owm_pkg::PH_IDLE;
              done             = 1'b1;
            end
          end
          owm_pkg::PH_RST_TAIL: begin
            phase_next = owm_pkg::PH_IDLE;
            done       = 1'b1;
          end
          owm_pkg::PH_BIT_LOW: begin
            if (active_command == owm_pkg::CMD_WRITE) begin
              if (shift_byte[0]) begin
                phase_next      = owm_pkg::PH_BIT_WAIT;
                wait_count_next = {2'b00, one_tail_us};
              end else begin
                phase_next      = owm_pkg::PH_RECOVER;
                wait_count_next = owm_pkg::RECOVERY_US;
              end
            end else begin
              phase_next      = owm_pkg::PH_BIT_WAIT;
              wait_count_next = {2'b00, read_sample_us};
            end
          end
          owm_pkg::PH_BIT_WAIT: begin
            if (active_command == owm_pkg::CMD_WRITE) begin
              phase_next      = owm_pkg::PH_RECOVER;
              wait_count_next = owm_pkg::RECOVERY_US;
            end else begin
              // Sample the read bit into the top, LSB arrives first
              shift_byte_next = {item.line_level, shift_byte[7:1]};
              phase_next      = owm_pkg::PH_READ_TAIL;
              wait_count_next = {2'b00, read_tail_us};
            end
          end
          owm_pkg::PH_READ_TAIL: begin
            phase_next      = owm_pkg::PH_RECOVER;
            wait_count_next = owm_pkg::RECOVERY_US;
          end
          owm_pkg::PH_RECOVER: begin
            if (active_command == owm_pkg::CMD_WRITE) begin
              shift_wr = {1'b0, shift_byte[7:1]};
            end
            shift_byte_next = shift_wr;
            if (bit_index == 3'd7) begin
              if (active_command == owm_pkg::CMD_READ) begin
                rx_last_next = shift_wr;
              end
              phase_next = owm_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = owm_pkg::PH_BIT_LOW;
              if (active_command == owm_pkg::CMD_WRITE) begin
                wait_count_next = {2'b00, shift_wr[0] ? write_one_low_us : write_zero_low_us};
              end else begin
                wait_count_next = {2'b00, read_low_us};
              end
            end
          end
          default: begin
            phase_next = owm_pkg::PH_IDLE;
          end
        endcase
        if (phase_next == owm_pkg::PH_IDLE) begin
          active_command_next = owm_pkg::CMD_NONE;
          wait_count_next     = 10'd0;
        end
      end
    end

    res.drive_low = (phase_next == owm_pkg::PH_RST_LOW) || (phase_next == owm_pkg::PH_BIT_LOW);
    res.busy_res  = (phase_next != owm_pkg::PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_last_next;
    res.status    = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= owm_pkg::PH_IDLE;
      active_command <= owm_pkg::CMD_NONE;
      wait_count     <= 10'd0;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      last_status    <= owm_pkg::STATUS_OK;
      rx_last        <= 8'd0;
    end else if (acc) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      wait_count     <= wait_count_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      last_status    <= last_status_next;
      rx_last        <= rx_last_next;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (acc) begin
      skid_data <= res;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive_low = out_data.drive_low;
  assign result.busy_res  = out_data.busy_res;
  assign result.done_res  = out_data.done_res;
  assign result.rx_byte   = out_data.rx_byte;
  assign result.status    = out_data.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted item produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done raised while still busy");

  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_low |-> out_data.busy_res)
    else $error("line driven low outside a command");

  a_idle_no_command: assert property (@(posedge clk) disable iff (rst)
    phase == owm_pkg::PH_IDLE |-> active_command == owm_pkg::CMD_NONE)
    else $error("command left active in idle");

endmodule
